@@ hw/rtl/asp_pkg.sv @@
// Shared types, constants and helpers for the adaptive position smoother.
// Used by the controller, the datapath and the top level; no dependencies.
package asp_pkg;

   localparam int POS_W    = 16;
   localparam int WEIGHT_W = 17;
   localparam int MAG_W    = 15;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 48;
   localparam int ADDR_W   = 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
   localparam logic [WEIGHT_W-1:0] ROUND_HALF = 17'h08000;

   localparam logic signed [POS_W-1:0]  MIN_LIMIT_RST   = 16'sd0;
   localparam logic signed [POS_W-1:0]  MAX_LIMIT_RST   = 16'sd3244;
   localparam logic [WEIGHT_W-1:0]      BASE_WEIGHT_RST = 17'd19661;

   localparam logic [ADDR_W-1:0] REG_MIN_LIMIT   = 2'd0;
   localparam logic [ADDR_W-1:0] REG_MAX_LIMIT   = 2'd1;
   localparam logic [ADDR_W-1:0] REG_BASE_WEIGHT = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic calc;
      logic mul;
      logic emit;
   } asp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic seeded;
      logic out_free;
   } asp_stat_type;

   function automatic logic signed [POS_W-1:0] clamp_pos(
      input logic signed [POS_W-1:0] p,
      input logic signed [POS_W-1:0] lo,
      input logic signed [POS_W-1:0] hi
   );
      logic signed [POS_W-1:0] r;
      if (p < lo)      r = lo;
      else if (p > hi) r = hi;
      else             r = p;
      return r;
   endfunction

endpackage

@@ hw/rtl/asp_ctrl.sv @@
// Sequencer of the adaptive position smoother: take, blend, emit.
// Depends on asp_pkg for the command and status structs.
module asp_ctrl import asp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  asp_stat_type stat,
   output asp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            // first word only seeds the filter
            state_in = stat.seeded ? ST_MUL : ST_EMIT;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/asp_dpath.sv @@
// Datapath of the adaptive position smoother: limit registers, clamp,
// adaptive weight, blend multiplier and output register. Depends on asp_pkg.
module asp_dpath import asp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  asp_cmd_type         cmd,
   output asp_stat_type        stat,
   input  logic [REQ_W-1:0]    req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ADDR_W-1:0]   csr_addr,
   input  logic [WEIGHT_W-1:0] csr_wdata
);

   logic signed [POS_W-1:0]   min_ff, max_ff;
   logic [WEIGHT_W-1:0]       base_ff;
   logic signed [POS_W-1:0]   clamped_ff, filt_ff, filt_in, pos_ff;
   logic [MAG_W-1:0]          speed_ff, force_ff, speed_in, force_in;
   logic [MAG_W-1:0]          speed_out_ff, force_out_ff;
   logic                      seeded_ff, valid_ff;
   logic signed [POS_W:0]     diff_ff, diff_in;
   logic [WEIGHT_W-1:0]       weight_ff, weight_in;

   logic signed [POS_W-1:0]   target, speed, force_v;
   logic [POS_W-1:0]          dist_mag, speed_abs;
   logic [22:0]               dist_x80;
   logic [WEIGHT_W-1:0]       raw_w, low_w;
   logic signed [34:0]        prod, biased;

   assign target  = req_tdata[15:0];
   assign speed   = req_tdata[31:16];
   assign force_v = req_tdata[47:32];

   assign csr_ready = 1'b1;

   always_comb begin
      speed_abs = speed[POS_W-1] ? (~speed + 16'd1) : speed;
      // most negative speed saturates
      speed_in  = speed_abs[POS_W-1] ? {MAG_W{1'b1}} : speed_abs[MAG_W-1:0];
      force_in  = force_v[POS_W-1] ? '0 : force_v[MAG_W-1:0];
   end

   // distance times 80 gives the weight in Q1.16, held in [min(base, 1.0), 1.0]
   always_comb begin
      diff_in  = {clamped_ff[POS_W-1], clamped_ff} - {filt_ff[POS_W-1], filt_ff};
      dist_mag = diff_in[POS_W] ? POS_W'(-diff_in) : diff_in[POS_W-1:0];
      dist_x80 = {1'b0, dist_mag, 6'b0} + {3'b0, dist_mag, 4'b0};
      raw_w    = (dist_x80 > 23'(WEIGHT_ONE)) ? WEIGHT_ONE : dist_x80[WEIGHT_W-1:0];
      low_w    = (base_ff > WEIGHT_ONE) ? WEIGHT_ONE : base_ff;
      weight_in = (raw_w < low_w) ? low_w : raw_w;
   end

   // f + floor((w*(c-f) + 0.5) / 1.0); result stays within 16 bits
   always_comb begin
      prod    = $signed({1'b0, weight_ff}) * diff_ff;
      biased  = prod + 35'(ROUND_HALF);
      filt_in = filt_ff + biased[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= MIN_LIMIT_RST;
         max_ff  <= MAX_LIMIT_RST;
         base_ff <= BASE_WEIGHT_RST;
      end else if (csr_valid) begin
         unique case (csr_addr)
            REG_MIN_LIMIT:   min_ff  <= csr_wdata[POS_W-1:0];
            REG_MAX_LIMIT:   max_ff  <= csr_wdata[POS_W-1:0];
            REG_BASE_WEIGHT: base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
         valid_ff  <= 1'b0;
         filt_ff   <= '0;
      end else begin
         if (cmd.calc && !seeded_ff) begin
            filt_ff   <= clamped_ff;
            seeded_ff <= 1'b1;
         end else if (cmd.mul) begin
            filt_ff <= filt_in;
         end
         if (cmd.emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         clamped_ff <= clamp_pos(target, min_ff, max_ff);
         speed_ff   <= speed_in;
         force_ff   <= force_in;
      end
      if (cmd.calc) begin
         diff_ff   <= diff_in;
         weight_ff <= weight_in;
      end
      if (cmd.emit) begin
         pos_ff       <= clamp_pos(filt_ff, min_ff, max_ff);
         speed_out_ff <= speed_ff;
         force_out_ff <= force_ff;
      end
   end

   assign stat.seeded   = seeded_ff;
   assign stat.out_free = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, force_out_ff, speed_out_ff, pos_ff};

endmodule

@@ hw/rtl/adaptive_position_smoother.sv @@
// Adaptive position smoother: one word in, one word out.
// The sequencer steps clamp, weight, blend multiply and emit one after the other
// (the first word skips the multiply) and takes no new word until the last is emitted.
// Reset: synchronous, clears the filter, its seed flag and the output valid, loads
// limit and base weight defaults; req is freed once a result enters the output
// register, which it enters only when empty or being taken.
module adaptive_position_smoother import asp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,   // target_pos, speed_req, force_req
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,   // smoothed_pos, speed_out, force_out, pad
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ADDR_W-1:0]   csr_addr,
   input  logic [WEIGHT_W-1:0] csr_wdata
);

   asp_cmd_type  cmd;
   asp_stat_type stat;

   asp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   asp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

endmodule

@@ hw/rtl/asp_checker.sv @@
// Port-level checks for the adaptive position smoother, bound to the top.
// Depends on asp_pkg for the port widths.
module asp_checker import asp_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [REQ_W-1:0]    req_tdata,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_W-1:0]    rsp_tdata,
   input logic                csr_valid,
   input logic                csr_ready,
   input logic [ADDR_W-1:0]   csr_addr,
   input logic [WEIGHT_W-1:0] csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:POS_W+2*MAG_W] == '0)
      else $error("rsp padding bits not zero");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("req taken while a word is in flight");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind adaptive_position_smoother asp_checker u_asp_checker (.*);

@@ tb/adaptive_position_smoother_test.sv @@
// Self-checking bench for adaptive_position_smoother: random and corner servo commands,
// limit and weight writes, stalls on both streams, checked against a built-in predictor.
// Depends on asp_pkg and the adaptive_position_smoother RTL.
module adaptive_position_smoother_test;
   import asp_pkg::*;

   localparam logic [ADDR_W-1:0] REG_SPARE = 2'd3;  // unmapped index, write must be dropped
   localparam longint FULL_WEIGHT   = 65536;
   localparam longint DIST_GAIN     = 80;           // 1 / 0.2 rad, Q4.12 step to Q1.16 weight
   localparam longint SPEED_MAX     = 32767;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     HOLD_CYCLES   = 80;
   localparam int     PHASES        = 10;
   localparam int     PHASE_ITEMS   = 65;
   localparam longint CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic [MAG_W-1:0]        speed_mag;
      logic [MAG_W-1:0]        effort;
   } servo_result_type;

   class smoother_scoreboard;
      logic signed [POS_W-1:0] lo_limit;
      logic signed [POS_W-1:0] hi_limit;
      logic signed [POS_W-1:0] filter_pos;
      logic [WEIGHT_W-1:0]     min_weight;
      bit                      seeded;
      servo_result_type        pending_q[$];
      int                      errors;

      function new();
         lo_limit   = MIN_LIMIT_RST;
         hi_limit   = MAX_LIMIT_RST;
         min_weight = BASE_WEIGHT_RST;
         filter_pos = '0;
         seeded     = 1'b0;
         errors     = 0;
      endfunction

      function void write_reg(logic [ADDR_W-1:0] addr, logic [WEIGHT_W-1:0] data);
         case (addr)
            REG_MIN_LIMIT:   lo_limit = data[POS_W-1:0];
            REG_MAX_LIMIT:   hi_limit = data[POS_W-1:0];
            REG_BASE_WEIGHT: min_weight = data;
            default: ;
         endcase
      endfunction

      // crossed limits: below lo_limit gives lo_limit, anything else hi_limit
      function logic signed [POS_W-1:0] limit_pos(logic signed [POS_W-1:0] p);
         if (p < lo_limit) return lo_limit;
         if (p > hi_limit) return hi_limit;
         return p;
      endfunction

      function void note_command(logic [REQ_W-1:0] word);
         logic signed [POS_W-1:0] target;
         logic signed [POS_W-1:0] speed;
         logic signed [POS_W-1:0] effort_req;
         longint c, f, d, w, floor_w, acc, mag;
         servo_result_type r;
         target     = word[15:0];
         speed      = word[31:16];
         effort_req = word[47:32];
         c = limit_pos(target);
         if (!seeded) begin
            filter_pos = c;
            seeded = 1'b1;
         end else begin
            f = filter_pos;
            d = (c >= f) ? c - f : f - c;
            floor_w = min_weight;
            if (floor_w > FULL_WEIGHT) floor_w = FULL_WEIGHT;
            w = d * DIST_GAIN;
            if (w > FULL_WEIGHT) w = FULL_WEIGHT;
            if (w < floor_w) w = floor_w;
            // round half up, floor via arithmetic shift
            acc = w * c + (FULL_WEIGHT - w) * f + FULL_WEIGHT / 2;
            acc = acc >>> 16;
            filter_pos = acc[POS_W-1:0];
         end
         mag = speed;
         if (mag < 0) mag = -mag;
         if (mag > SPEED_MAX) mag = SPEED_MAX;
         r.pos       = limit_pos(filter_pos);
         r.speed_mag = mag[MAG_W-1:0];
         r.effort    = (effort_req > 0) ? effort_req[MAG_W-1:0] : '0;
         pending_q.push_back(r);
      endfunction

      function void check_result(logic [RSP_W-1:0] word);
         servo_result_type want;
         servo_result_type got;
         got.pos       = word[15:0];
         got.speed_mag = word[30:16];
         got.effort    = word[45:31];
         if (pending_q.size() == 0) begin
            $error("rsp word %h with no command waiting", word);
            errors++;
         end else begin
            want = pending_q.pop_front();
            if (got.pos !== want.pos) begin
               $error("smoothed_pos: expected %0d, got %0d", want.pos, got.pos);
               errors++;
            end
            if (got.speed_mag !== want.speed_mag) begin
               $error("speed_out: expected %0d, got %0d", want.speed_mag, got.speed_mag);
               errors++;
            end
            if (got.effort !== want.effort) begin
               $error("force_out: expected %0d, got %0d", want.effort, got.effort);
               errors++;
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;   // target_pos, speed_req, force_req
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;        // smoothed_pos, speed_out, force_out, pad
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ADDR_W-1:0]   csr_addr = '0;
   logic [WEIGHT_W-1:0] csr_wdata = '0;

   smoother_scoreboard sb;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     hold_asks = 0;
   int     hold_seen = 0;
   int     hold_left = 0;
   longint cycle_count = 0;

   adaptive_position_smoother dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("adaptive_position_smoother_test failed");
         $finish;
      end
   end

   // receiver: random back-pressure, or a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // results are checked before the same edge's command is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_command(req_tdata);
         if (csr_valid && csr_ready) sb.write_reg(csr_addr, csr_wdata);
      end
   end

   // valid stays high between back-to-back words; lowered only for a gap
   task automatic send_command(input logic [15:0] target, input logic [15:0] speed,
                               input logic [15:0] effort);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {effort, speed, target};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ADDR_W-1:0] addr, input logic [WEIGHT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // step one edge first so the last accepted word is already queued
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int lo, hi, tgt, prev, pick;
      logic [WEIGHT_W-1:0] base;
      logic [15:0] spd, eff;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 38;
      recv_idle_pct = 45;

      // reset limits: seed, then clamp at both ends
      send_command(16'd1000, 16'h0000, 16'h0000);
      send_command(16'h7FFF, 16'h8000, 16'h8000);
      send_command(16'h8000, 16'h7FFF, 16'h7FFF);
      send_command(16'd3244, 16'hFFFF, 16'h0001);
      send_command(16'd3000, 16'h0001, 16'hFFFF);
      drain_results();

      // widest window, zero base weight: weight comes from distance alone
      write_csr(REG_MIN_LIMIT, 17'h18000);
      write_csr(REG_MAX_LIMIT, 17'h07FFF);
      write_csr(REG_BASE_WEIGHT, 17'd0);
      write_csr(REG_SPARE, 17'h1FFFF);
      send_command(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_command(16'h8000, 16'h8000, 16'h8000);
      send_command(16'h0000, 16'h0000, 16'h0000);
      send_command(16'h0001, 16'hFFFF, 16'h0001);
      send_command(16'h0003, 16'h0001, 16'hFFFF);
      send_command(16'h0400, 16'h1234, 16'h4321);
      drain_results();

      // crossed limits, base weight above one
      write_csr(REG_MIN_LIMIT, 17'd1000);
      write_csr(REG_MAX_LIMIT, {1'b0, 16'hFC18});
      write_csr(REG_BASE_WEIGHT, 17'd65537);
      send_command(16'hF830, 16'h8001, 16'h0000);
      send_command(16'd2000, 16'h0100, 16'h7FFF);
      send_command(16'd0, 16'h0000, 16'h8000);
      drain_results();

      // narrow window, largest base weight
      write_csr(REG_MIN_LIMIT, {1'b1, 16'hFFFB});
      write_csr(REG_MAX_LIMIT, 17'd5);
      write_csr(REG_BASE_WEIGHT, 17'h1FFFF);
      send_command(16'd100, 16'h00FF, 16'h00FF);
      send_command(16'hFF9C, 16'hFF00, 16'hFF00);
      send_command(16'd3, 16'h5555, 16'hAAAA);
      drain_results();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 38;
            recv_idle_pct = 45;
         end else if (ph < 6) begin
            send_idle_pct = 45;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (ph)
            0: begin
               lo = -32768; hi = 32767; base = 17'd0;
            end
            1: begin
               lo = 32767; hi = -32768; base = 17'h1FFFF;
            end
            default: begin
               case ($urandom_range(3))
                  0: begin
                     lo = int'($urandom_range(0, 65535)) - 32768;
                     hi = lo + int'($urandom_range(0, 8000));
                     if (hi > 32767) hi = 32767;
                  end
                  1: begin
                     lo = int'($urandom_range(0, 65535)) - 32768;
                     hi = int'($urandom_range(0, 65535)) - 32768;
                  end
                  2: begin
                     lo = -32768; hi = 32767;
                  end
                  default: begin
                     lo = -int'($urandom_range(0, 4096));
                     hi = int'($urandom_range(0, 4096));
                  end
               endcase
               case ($urandom_range(4))
                  0: base = 17'd0;
                  1: base = 17'd65536;
                  2: base = 17'd65536 + 17'($urandom_range(1, 65535));
                  3: base = 17'($urandom_range(0, 65536));
                  default: base = BASE_WEIGHT_RST;
               endcase
            end
         endcase
         write_csr(REG_MIN_LIMIT, {1'($urandom_range(1)), 16'(lo)});
         write_csr(REG_MAX_LIMIT, {1'($urandom_range(1)), 16'(hi)});
         write_csr(REG_BASE_WEIGHT, base);
         if ($urandom_range(3) == 0) write_csr(REG_SPARE, 17'($urandom_range(0, 131071)));
         prev = lo;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // starve the output so the block backs up into req, or drain midway
            if (ph == 0 && n == 20) hold_asks++;
            if (ph == 1 && n == 30) drain_results();
            pick = $urandom_range(99);
            if (pick < 45)
               tgt = prev + int'($urandom_range(0, 1800)) - 900;
            else if (pick < 70)
               tgt = int'($urandom_range(0, 65535)) - 32768;
            else if (pick < 85)
               tgt = ($urandom_range(1) != 0) ? 32767 : -32768;
            else
               tgt = (($urandom_range(1) != 0) ? lo : hi) + int'($urandom_range(0, 8)) - 4;
            if (tgt > 32767) tgt = 32767;
            if (tgt < -32768) tgt = -32768;
            prev = tgt;
            spd = 16'($urandom_range(0, 65535));
            eff = 16'($urandom_range(0, 65535));
            if ($urandom_range(9) == 0) spd = 16'h8000;
            send_command(16'(tgt), spd, eff);
         end
         drain_results();
      end

      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("adaptive_position_smoother_test passed");
      else
         $display("adaptive_position_smoother_test failed");
      $finish;
   end

endmodule
